[rtl/barm_pkg.sv]
// Package for the block average rank matcher: transaction structs, codes and constants.
// Used by every file in rtl; depends on nothing.
package barm_pkg;

    // Fixed sizes of the tile stores and the geometry limits.
    localparam int MAX_TILES     = 1024;
    localparam int TILE_W        = 10;
    localparam int MAX_TILE_EDGE = 64;
    localparam int GRID_LIMIT    = 32;
    localparam int SUM_W         = 20;
    localparam int KEY_W         = 24;

    // Shared divider widths: dividend covers a channel sum, divisor a tile area.
    localparam int DIV_DW = 20;
    localparam int DIV_VW = 13;

    // Request modes.
    localparam logic [2:0] MODE_ORIG  = 3'd0;
    localparam logic [2:0] MODE_REF   = 3'd1;
    localparam logic [2:0] MODE_SORT  = 3'd2;
    localparam logic [2:0] MODE_QUERY = 3'd3;
    localparam logic [2:0] MODE_CLEAR = 3'd4;

    // Response status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_UNSORTED = 2'd1;
    localparam logic [1:0] STATUS_RANGE    = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BLOCK_SIZE   = 2'd0;
    localparam logic [1:0] CFG_TILES_ACROSS = 2'd1;
    localparam logic [1:0] CFG_TILES_DOWN   = 2'd2;

    typedef struct packed {
        logic [2:0]  mode;
        logic [10:0] pixel_x;
        logic [10:0] pixel_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [9:0]  query_tile;
    } req_t;

    typedef struct packed {
        logic [4:0] source_tile_x;
        logic [4:0] source_tile_y;
        logic [1:0] status;
    } rsp_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE,
        S_PDIV, S_PRD, S_PWR,
        S_KRD, S_KDAT, S_KDIV,
        S_RKEY, S_RKEYW, S_RSCAN, S_RORD, S_RMAP,
        S_QRD, S_QDAT, S_QDIV, S_QOUT
    } state_t;

    // Average of one channel, saturated to eight bits.
    function automatic logic [7:0] sat8(input logic [DIV_DW-1:0] v);
        return (v > DIV_DW'(255)) ? 8'hFF : v[7:0];
    endfunction

endpackage

[rtl/barm_div.sv]
// Restoring divider, one quotient bit per cycle, for the block average rank matcher.
// Depends on barm_pkg for its widths.
module barm_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [barm_pkg::DIV_DW-1:0] dividend,
    input  logic [barm_pkg::DIV_VW-1:0] divisor,
    output logic                        done,
    output logic [barm_pkg::DIV_DW-1:0] quot,
    output logic [barm_pkg::DIV_VW-1:0] rem
);

    localparam int DW = barm_pkg::DIV_DW;
    localparam int VW = barm_pkg::DIV_VW;
    localparam int CW = $clog2(DW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] count_reg;
    logic [DW-1:0] quot_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dvs_reg;

    logic [VW:0]   shifted;
    logic [VW+1:0] diff;

    // One trial subtraction of the divisor from the shifted remainder.
    assign shifted = {rem_reg, quot_reg[DW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    // Control: busy from start until the count runs out, done pulses once at the end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CW'(DW);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient shifts in from the right as dividend bits leave.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[VW+1])
            begin
                rem_reg  <= diff[VW-1:0];
                quot_reg <= {quot_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= shifted[VW-1:0];
                quot_reg <= {quot_reg[DW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

[rtl/block_average_rank_matcher.sv]
// Pixel transaction: 20-step shared divider for the tile column and row, then one sum
// read-modify-write. Query: map read and a 20-step divide; an error skips both.
// Sort: average keys for both images, then rank scans that read all n keys for each
// of the n tiles, n = tiles_across * tiles_down. One request is in work at a time.
// Reset and the clear command start a clearing pass over the sum memory,
// during which no request is taken; configuration returns to 8, 32, 32 at reset.
module block_average_rank_matcher
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  barm_pkg::req_t    req_data,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output barm_pkg::rsp_t    rsp_data,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [6:0]        cfg_data
);

    localparam int TW = barm_pkg::TILE_W;
    localparam int AW = TW + 1;

    // Memories: sums and keys hold both images, the image bit on top of the address.
    logic [59:0] sum_mem [2*barm_pkg::MAX_TILES];
    logic [23:0] key_mem [2*barm_pkg::MAX_TILES];
    logic [9:0]  ord_mem [barm_pkg::MAX_TILES];
    logic [9:0]  map_mem [barm_pkg::MAX_TILES];

    logic          sum_we;
    logic [AW-1:0] sum_waddr, sum_raddr;
    logic [59:0]   sum_wdata, sum_rdata_reg;
    logic          key_we;
    logic [AW-1:0] key_waddr, key_raddr;
    logic [23:0]   key_wdata, key_rdata_reg;
    logic          ord_we;
    logic [TW-1:0] ord_waddr, ord_raddr;
    logic [9:0]    ord_wdata, ord_rdata_reg;
    logic          map_we;
    logic [TW-1:0] map_waddr, map_raddr;
    logic [9:0]    map_wdata, map_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (sum_we)
            sum_mem[sum_waddr] <= sum_wdata;
        sum_rdata_reg <= sum_mem[sum_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[key_waddr] <= key_wdata;
        key_rdata_reg <= key_mem[key_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
            ord_mem[ord_waddr] <= ord_wdata;
        ord_rdata_reg <= ord_mem[ord_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_waddr] <= map_wdata;
        map_rdata_reg <= map_mem[map_raddr];
    end

    // Registers.
    barm_pkg::state_t state_reg, state_next;
    logic          sorted_reg, sorted_next;
    logic [6:0]    bs_reg, bs_next;
    logic [5:0]    ta_reg, ta_next;
    logic [5:0]    td_reg, td_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] j_reg, j_next;
    logic [TW-1:0] jd_reg, jd_next;
    logic          scan_v_reg, scan_v_next;
    logic [AW-1:0] rank_reg, rank_next;
    logic          sel_reg, sel_next;
    logic [23:0]   key_i_reg, key_i_next;
    logic [7:0]    pr_reg, pr_next, pg_reg, pg_next, pb_reg, pb_next;
    logic [TW-1:0] tile_reg, tile_next;
    logic [TW-1:0] q_reg, q_next;
    barm_pkg::rsp_t res_reg, res_next;
    logic          rsp_valid_reg, rsp_valid_next;
    barm_pkg::rsp_t rsp_data_reg, rsp_data_next;

    // Shared dividers.
    logic                        div_start;
    logic [barm_pkg::DIV_DW-1:0] div_a0, div_a1, div_a2;
    logic [barm_pkg::DIV_VW-1:0] div_b;
    logic                        div_done0, div_done1, div_done2;
    logic [barm_pkg::DIV_DW-1:0] div_q0, div_q1, div_q2;
    logic [barm_pkg::DIV_VW-1:0] div_r0, div_r1, div_r2;

    barm_div u_div0 (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a0),
                     .divisor(div_b), .done(div_done0), .quot(div_q0), .rem(div_r0));
    barm_div u_div1 (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a1),
                     .divisor(div_b), .done(div_done1), .quot(div_q1), .rem(div_r1));
    barm_div u_div2 (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a2),
                     .divisor(div_b), .done(div_done2), .quot(div_q2), .rem(div_r2));

    // Effective geometry after clamping the registers.
    logic [6:0]  edge_len;
    logic [5:0]  across, down;
    logic [12:0] x_lim, y_lim, area;
    logic [11:0] n_full;
    logic [AW-1:0] n_tiles;
    logic        accept;
    logic        in_range;
    logic [10:0] tidx;

    always_comb
    begin
        if (bs_reg == 7'd0)
            edge_len = 7'd1;
        else if (bs_reg > 7'(barm_pkg::MAX_TILE_EDGE))
            edge_len = 7'(barm_pkg::MAX_TILE_EDGE);
        else
            edge_len = bs_reg;
        if (ta_reg == 6'd0)
            across = 6'd1;
        else if (ta_reg > 6'(barm_pkg::GRID_LIMIT))
            across = 6'(barm_pkg::GRID_LIMIT);
        else
            across = ta_reg;
        if (td_reg == 6'd0)
            down = 6'd1;
        else if (td_reg > 6'(barm_pkg::GRID_LIMIT))
            down = 6'(barm_pkg::GRID_LIMIT);
        else
            down = td_reg;
    end

    assign x_lim   = {7'd0, across} * {6'd0, edge_len};
    assign y_lim   = {7'd0, down} * {6'd0, edge_len};
    assign area    = {6'd0, edge_len} * {6'd0, edge_len};
    assign n_full  = {6'd0, across} * {6'd0, down};
    assign n_tiles = n_full[AW-1:0];
    assign accept  = req_valid && !req_stall;
    assign in_range = ({2'b00, req_data.pixel_x} < x_lim) &&
                      ({2'b00, req_data.pixel_y} < y_lim);
    assign tidx    = {6'd0, div_q1[4:0]} * {5'd0, across} + {6'd0, div_q0[4:0]};

    // Next state, datapath and memory control.
    always_comb
    begin
        state_next     = state_reg;
        sorted_next    = sorted_reg;
        bs_next        = bs_reg;
        ta_next        = ta_reg;
        td_next        = td_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        jd_next        = jd_reg;
        scan_v_next    = 1'b0;
        rank_next      = rank_reg;
        sel_next       = sel_reg;
        key_i_next     = key_i_reg;
        pr_next        = pr_reg;
        pg_next        = pg_reg;
        pb_next        = pb_reg;
        tile_next      = tile_reg;
        q_next         = q_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_data_next  = rsp_data_reg;

        sum_we    = 1'b0;
        sum_waddr = '0;
        sum_wdata = '0;
        sum_raddr = '0;
        key_we    = 1'b0;
        key_waddr = '0;
        key_wdata = '0;
        key_raddr = '0;
        ord_we    = 1'b0;
        ord_waddr = '0;
        ord_wdata = '0;
        ord_raddr = '0;
        map_we    = 1'b0;
        map_waddr = '0;
        map_wdata = '0;
        map_raddr = '0;

        div_start = 1'b0;
        div_a0    = '0;
        div_a1    = '0;
        div_a2    = '0;
        div_b     = {6'd0, edge_len};

        req_stall = (state_reg != barm_pkg::S_IDLE);

        unique case (state_reg)
            // Sweep zeros through both images' sums.
            barm_pkg::S_CLEAR:
            begin
                sum_we    = 1'b1;
                sum_waddr = i_reg;
                i_next    = i_reg + 1'b1;
                if (i_reg == '1)
                begin
                    i_next     = '0;
                    state_next = barm_pkg::S_IDLE;
                end
            end

            // Take a request and dispatch by mode.
            barm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_data.mode)
                        barm_pkg::MODE_ORIG, barm_pkg::MODE_REF:
                        begin
                            if (in_range)
                            begin
                                sel_next   = req_data.mode[0];
                                pr_next    = req_data.red;
                                pg_next    = req_data.green;
                                pb_next    = req_data.blue;
                                div_start  = 1'b1;
                                div_a0     = {9'd0, req_data.pixel_x};
                                div_a1     = {9'd0, req_data.pixel_y};
                                state_next = barm_pkg::S_PDIV;
                            end
                        end
                        barm_pkg::MODE_SORT:
                        begin
                            i_next     = '0;
                            sel_next   = 1'b0;
                            state_next = barm_pkg::S_KRD;
                        end
                        barm_pkg::MODE_QUERY:
                        begin
                            q_next = req_data.query_tile;
                            res_next = '0;
                            if (!sorted_reg)
                            begin
                                res_next.status = barm_pkg::STATUS_UNSORTED;
                                state_next      = barm_pkg::S_QOUT;
                            end
                            else if ({1'b0, req_data.query_tile} >= n_tiles)
                            begin
                                res_next.status = barm_pkg::STATUS_RANGE;
                                state_next      = barm_pkg::S_QOUT;
                            end
                            else
                                state_next = barm_pkg::S_QRD;
                        end
                        barm_pkg::MODE_CLEAR:
                        begin
                            sorted_next = 1'b0;
                            i_next      = '0;
                            state_next  = barm_pkg::S_CLEAR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Pixel: wait for tile column and row, then read-modify-write the sums.
            barm_pkg::S_PDIV:
            begin
                if (div_done0)
                begin
                    tile_next  = tidx[TW-1:0];
                    state_next = barm_pkg::S_PRD;
                end
            end
            barm_pkg::S_PRD:
            begin
                sum_raddr  = {sel_reg, tile_reg};
                state_next = barm_pkg::S_PWR;
            end
            barm_pkg::S_PWR:
            begin
                sum_we    = 1'b1;
                sum_waddr = {sel_reg, tile_reg};
                sum_wdata = {sum_rdata_reg[59:40] + {12'd0, pr_reg},
                             sum_rdata_reg[39:20] + {12'd0, pg_reg},
                             sum_rdata_reg[19:0]  + {12'd0, pb_reg}};
                state_next = barm_pkg::S_IDLE;
            end

            // Sort, first pass: average keys for every tile of both images.
            barm_pkg::S_KRD:
            begin
                sum_raddr  = {sel_reg, i_reg[TW-1:0]};
                state_next = barm_pkg::S_KDAT;
            end
            barm_pkg::S_KDAT:
            begin
                div_start  = 1'b1;
                div_a0     = sum_rdata_reg[59:40];
                div_a1     = sum_rdata_reg[39:20];
                div_a2     = sum_rdata_reg[19:0];
                div_b      = area;
                state_next = barm_pkg::S_KDIV;
            end
            barm_pkg::S_KDIV:
            begin
                if (div_done0)
                begin
                    key_we    = 1'b1;
                    key_waddr = {sel_reg, i_reg[TW-1:0]};
                    key_wdata = {barm_pkg::sat8(div_q0), barm_pkg::sat8(div_q1),
                                 barm_pkg::sat8(div_q2)};
                    i_next     = i_reg + 1'b1;
                    state_next = barm_pkg::S_KRD;
                    if (i_reg + 1'b1 == n_tiles)
                    begin
                        i_next = '0;
                        if (sel_reg)
                        begin
                            sel_next   = 1'b0;
                            state_next = barm_pkg::S_RKEY;
                        end
                        else
                            sel_next = 1'b1;
                    end
                end
            end

            // Sort, second pass: rank of tile i is the count of smaller (key, index) pairs.
            barm_pkg::S_RKEY:
            begin
                key_raddr  = {sel_reg, i_reg[TW-1:0]};
                state_next = barm_pkg::S_RKEYW;
            end
            barm_pkg::S_RKEYW:
            begin
                key_i_next = key_rdata_reg;
                j_next     = '0;
                rank_next  = '0;
                state_next = barm_pkg::S_RSCAN;
            end
            barm_pkg::S_RSCAN:
            begin
                if (j_reg < n_tiles)
                begin
                    key_raddr   = {sel_reg, j_reg[TW-1:0]};
                    jd_next     = j_reg[TW-1:0];
                    j_next      = j_reg + 1'b1;
                    scan_v_next = 1'b1;
                end
                if (scan_v_reg &&
                    ({key_rdata_reg, jd_reg} < {key_i_reg, i_reg[TW-1:0]}))
                    rank_next = rank_reg + 1'b1;
                if (j_reg == n_tiles && !scan_v_reg)
                    state_next = barm_pkg::S_RORD;
            end
            barm_pkg::S_RORD:
            begin
                if (!sel_reg)
                begin
                    // Original image: record which tile holds this rank.
                    ord_we     = 1'b1;
                    ord_waddr  = rank_reg[TW-1:0];
                    ord_wdata  = i_reg[TW-1:0];
                    i_next     = i_reg + 1'b1;
                    state_next = barm_pkg::S_RKEY;
                    if (i_reg + 1'b1 == n_tiles)
                    begin
                        i_next   = '0;
                        sel_next = 1'b1;
                    end
                end
                else
                begin
                    ord_raddr  = rank_reg[TW-1:0];
                    state_next = barm_pkg::S_RMAP;
                end
            end
            barm_pkg::S_RMAP:
            begin
                // Reference image: map this tile to the original tile of equal rank.
                map_we     = 1'b1;
                map_waddr  = i_reg[TW-1:0];
                map_wdata  = ord_rdata_reg;
                i_next     = i_reg + 1'b1;
                state_next = barm_pkg::S_RKEY;
                if (i_reg + 1'b1 == n_tiles)
                begin
                    i_next      = '0;
                    sel_next    = 1'b0;
                    sorted_next = 1'b1;
                    state_next  = barm_pkg::S_IDLE;
                end
            end

            // Query: read the map and split the tile index into column and row.
            barm_pkg::S_QRD:
            begin
                map_raddr  = q_reg;
                state_next = barm_pkg::S_QDAT;
            end
            barm_pkg::S_QDAT:
            begin
                div_start  = 1'b1;
                div_a0     = {10'd0, map_rdata_reg};
                div_b      = {7'd0, across};
                state_next = barm_pkg::S_QDIV;
            end
            barm_pkg::S_QDIV:
            begin
                if (div_done0)
                begin
                    res_next.source_tile_x = div_r0[4:0];
                    res_next.source_tile_y = div_q0[4:0];
                    res_next.status        = barm_pkg::STATUS_OK;
                    state_next             = barm_pkg::S_QOUT;
                end
            end
            barm_pkg::S_QOUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = res_reg;
                    state_next     = barm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = barm_pkg::S_IDLE;
            end
        endcase

        // Configuration writes; any existing register invalidates the sort.
        if (cfg_we)
        begin
            unique case (cfg_index)
                barm_pkg::CFG_BLOCK_SIZE:
                begin
                    bs_next     = cfg_data;
                    sorted_next = 1'b0;
                end
                barm_pkg::CFG_TILES_ACROSS:
                begin
                    ta_next     = cfg_data[5:0];
                    sorted_next = 1'b0;
                end
                barm_pkg::CFG_TILES_DOWN:
                begin
                    td_next     = cfg_data[5:0];
                    sorted_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= barm_pkg::S_CLEAR;
            sorted_reg    <= 1'b0;
            bs_reg        <= 7'd8;
            ta_reg        <= 6'd32;
            td_reg        <= 6'd32;
            i_reg         <= '0;
            j_reg         <= '0;
            scan_v_reg    <= 1'b0;
            rank_reg      <= '0;
            sel_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sorted_reg    <= sorted_next;
            bs_reg        <= bs_next;
            ta_reg        <= ta_next;
            td_reg        <= td_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            scan_v_reg    <= scan_v_next;
            rank_reg      <= rank_next;
            sel_reg       <= sel_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        jd_reg       <= jd_next;
        key_i_reg    <= key_i_next;
        pr_reg       <= pr_next;
        pg_reg       <= pg_next;
        pb_reg       <= pb_next;
        tile_reg     <= tile_next;
        q_reg        <= q_next;
        res_reg      <= res_next;
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // Only divider 0 paces the sequencer; the others finish on the same cycle.
    logic unused_div;
    assign unused_div = div_done1 ^ div_done2 ^ (^div_r1) ^ (^div_r2) ^ (^n_full[11]);

endmodule

[rtl/barm_checker.sv]
// Port-level checker for the block average rank matcher, bound to the top level.
// Depends on barm_pkg and block_average_rank_matcher.
module barm_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input barm_pkg::req_t req_data,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input barm_pkg::rsp_t rsp_data
);

    // A stalled response stays up.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("response dropped while stalled");

    // A stalled response keeps its payload.
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp_data))
        else $error("response payload changed while stalled");

    // Error responses carry zero coordinates.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != barm_pkg::STATUS_OK |->
        rsp_data.source_tile_x == 5'd0 && rsp_data.source_tile_y == 5'd0)
        else $error("error response with nonzero coordinates");

    // Query, sort and clear transactions stall the request side in the cycle after they are taken.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall &&
        (req_data.mode == barm_pkg::MODE_QUERY || req_data.mode == barm_pkg::MODE_SORT ||
         req_data.mode == barm_pkg::MODE_CLEAR) |=> req_stall)
        else $error("request taken while previous command in work");

endmodule

bind block_average_rank_matcher barm_checker u_barm_checker (.*);

[tb/block_average_rank_matcher_test.sv]
// Testbench for block_average_rank_matcher: directed and random pixel, sort and query traffic
// is checked against a predictor of the tile sums, ranking and tile map. Depends on barm_pkg and the top level.
`timescale 1ns / 1ps

module block_average_rank_matcher_test;

    localparam logic [1:0] CFG_UNUSED  = 2'd3;
    localparam logic [2:0] MODE_SPARE  = 3'd5;
    localparam logic [2:0] MODE_SPARE2 = 3'd6;
    localparam logic [2:0] MODE_SPARE3 = 3'd7;
    localparam int         IDLE_LIMIT  = 20000;
    localparam int         SETTLE      = 6000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    barm_pkg::req_t req_data;
    logic rsp_valid;
    logic rsp_stall;
    barm_pkg::rsp_t rsp_data;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [6:0] cfg_data;

    block_average_rank_matcher u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: sums per tile, tile map, sorted flag and registers.
    logic [59:0] orig_sums [barm_pkg::MAX_TILES];
    logic [59:0] ref_sums [barm_pkg::MAX_TILES];
    logic [9:0]  map_of_tile [barm_pkg::MAX_TILES];
    logic [39:0] rank_keys [barm_pkg::MAX_TILES];
    logic [9:0]  orig_order [barm_pkg::MAX_TILES];
    logic [9:0]  ref_order [barm_pkg::MAX_TILES];
    logic        is_sorted;
    logic [6:0]  reg_edge;
    logic [5:0]  reg_across;
    logic [5:0]  reg_down;

    barm_pkg::req_t pending_reqs[$];
    barm_pkg::rsp_t expected_rsps[$];

    int   errors;
    int   reqs_taken;
    int   rsps_checked;
    int   idle_cycles;
    int   gap_left;
    int   stall_left;
    bit   no_idle;
    bit   hold_off;
    bit   req_taken;
    bit   rsp_taken;

    // Clock.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int eff_edge();
        return (reg_edge == 0) ? 1 :
               (reg_edge > barm_pkg::MAX_TILE_EDGE) ? barm_pkg::MAX_TILE_EDGE : reg_edge;
    endfunction

    function automatic int eff_across();
        return (reg_across == 0) ? 1 :
               (reg_across > barm_pkg::GRID_LIMIT) ? barm_pkg::GRID_LIMIT : reg_across;
    endfunction

    function automatic int eff_down();
        return (reg_down == 0) ? 1 :
               (reg_down > barm_pkg::GRID_LIMIT) ? barm_pkg::GRID_LIMIT : reg_down;
    endfunction

    function automatic int tile_total();
        int n;
        n = eff_across() * eff_down();
        return (n > barm_pkg::MAX_TILES) ? barm_pkg::MAX_TILES : n;
    endfunction

    // Appends to the queues of pending requests and expected responses.
    function automatic void queue_req(barm_pkg::req_t r);
        pending_reqs = {pending_reqs, r};
    endfunction

    function automatic void add_expected(barm_pkg::rsp_t e);
        expected_rsps = {expected_rsps, e};
    endfunction

    // Averages one 20-bit channel sum over the tile area, saturating at 255.
    function automatic logic [7:0] channel_mean(logic [19:0] s, int area);
        int a;
        a = s / area;
        return (a > 255) ? 8'd255 : a[7:0];
    endfunction

    // Adds one pixel to the sums of its tile; pixels outside the tiled area are dropped.
    function automatic void accumulate(bit is_ref, barm_pkg::req_t r);
        int edge_len;
        int idx;
        logic [59:0] s;
        logic [19:0] cr;
        logic [19:0] cg;
        logic [19:0] cb;
        edge_len = eff_edge();
        if (r.pixel_x >= eff_across() * edge_len || r.pixel_y >= eff_down() * edge_len)
            return;
        idx = (r.pixel_y / edge_len) * eff_across() + r.pixel_x / edge_len;
        if (idx >= barm_pkg::MAX_TILES)
            return;
        s = is_ref ? ref_sums[idx] : orig_sums[idx];
        cr = s[59:40] + r.red;
        cg = s[39:20] + r.green;
        cb = s[19:0] + r.blue;
        if (is_ref)
            ref_sums[idx] = {cr, cg, cb};
        else
            orig_sums[idx] = {cr, cg, cb};
    endfunction

    // Ranks tiles by average color key, ties going to the lower raster index.
    function automatic void rank_by_color(bit is_ref, int n, int area);
        logic [59:0] s;
        logic [39:0] k;
        int j;
        for (int i = 0; i < n; i++)
        begin
            s = is_ref ? ref_sums[i] : orig_sums[i];
            k = {channel_mean(s[59:40], area), channel_mean(s[39:20], area),
                 channel_mean(s[19:0], area), 16'(i)};
            j = i;
            while (j > 0 && rank_keys[j - 1] > k)
            begin
                rank_keys[j] = rank_keys[j - 1];
                j--;
            end
            rank_keys[j] = k;
        end
        for (int i = 0; i < n; i++)
            if (is_ref)
                ref_order[i] = rank_keys[i][9:0];
            else
                orig_order[i] = rank_keys[i][9:0];
    endfunction

    function automatic void clear_sums();
        for (int i = 0; i < barm_pkg::MAX_TILES; i++)
        begin
            orig_sums[i] = '0;
            ref_sums[i] = '0;
        end
        is_sorted = 1'b0;
    endfunction

    // Applies one accepted transaction and queues the response it should cause.
    function automatic void predict_match(barm_pkg::req_t r);
        int n;
        int area;
        barm_pkg::rsp_t e;
        case (r.mode)
            barm_pkg::MODE_ORIG:  accumulate(1'b0, r);
            barm_pkg::MODE_REF:   accumulate(1'b1, r);
            barm_pkg::MODE_SORT:
            begin
                n = tile_total();
                area = eff_edge() * eff_edge();
                rank_by_color(1'b0, n, area);
                rank_by_color(1'b1, n, area);
                for (int i = 0; i < n; i++)
                    map_of_tile[ref_order[i]] = orig_order[i];
                is_sorted = 1'b1;
            end
            barm_pkg::MODE_CLEAR: clear_sums();
            barm_pkg::MODE_QUERY:
            begin
                e = '0;
                if (!is_sorted)
                    e.status = barm_pkg::STATUS_UNSORTED;
                else if (r.query_tile >= tile_total())
                    e.status = barm_pkg::STATUS_RANGE;
                else
                begin
                    e.source_tile_x = 5'(map_of_tile[r.query_tile] % eff_across());
                    e.source_tile_y = 5'(map_of_tile[r.query_tile] / eff_across());
                    e.status = barm_pkg::STATUS_OK;
                end
                add_expected(e);
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch %0d: %s got %0d expected %0d at %0t",
                 errors, what, got, want, $realtime);
    endtask

    // Sampling at the rising edge: acceptance, prediction, checking and the watchdog.
    always @(posedge clk)
    begin
        barm_pkg::rsp_t e;
        req_taken = rst_n && req_valid && !req_stall;
        rsp_taken = rst_n && rsp_valid && !rsp_stall;
        if (req_taken)
        begin
            predict_match(req_data);
            reqs_taken++;
        end
        if (rsp_taken)
        begin
            if (expected_rsps.size() == 0)
                report_mismatch("unexpected response count", 1, 0);
            else
            begin
                e = expected_rsps.pop_front();
                rsps_checked++;
                if (rsp_data.status != e.status)
                    report_mismatch("status", rsp_data.status, e.status);
                if (rsp_data.source_tile_x != e.source_tile_x)
                    report_mismatch("source_tile_x", rsp_data.source_tile_x, e.source_tile_x);
                if (rsp_data.source_tile_y != e.source_tile_y)
                    report_mismatch("source_tile_y", rsp_data.source_tile_y, e.source_tile_y);
            end
        end
        if (req_taken || rsp_taken || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog expired with %0d responses outstanding", expected_rsps.size());
            $display("block_average_rank_matcher_test: FAIL");
            $finish;
        end
    end

    // Request driver: holds a stalled transaction, otherwise idles or sends the next one.
    always @(negedge clk)
    begin
        if (!(req_valid && !req_taken))
        begin
            if (gap_left > 0)
            begin
                req_valid <= 1'b0;
                gap_left--;
            end
            else if (pending_reqs.size() > 0 && !hold_off)
            begin
                req_data <= pending_reqs.pop_front();
                req_valid <= 1'b1;
                gap_left = no_idle ? 0 : $urandom_range(0, 15);
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Response stall: a fresh wait is drawn after every accepted response.
    always @(negedge clk)
    begin
        if (rsp_taken)
            stall_left = no_idle ? 0 : $urandom_range(0, 15);
        if (stall_left > 0)
        begin
            rsp_stall <= 1'b1;
            stall_left--;
        end
        else
            rsp_stall <= 1'b0;
    end

    function automatic barm_pkg::req_t noise_req(logic [2:0] mode);
        barm_pkg::req_t r;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        r = raw[$bits(barm_pkg::req_t)-1:0];
        r.mode = mode;
        return r;
    endfunction

    function automatic barm_pkg::req_t pixel_at(bit is_ref, int x, int y);
        barm_pkg::req_t r;
        r = noise_req(is_ref ? barm_pkg::MODE_REF : barm_pkg::MODE_ORIG);
        r.pixel_x = 11'(x);
        r.pixel_y = 11'(y);
        return r;
    endfunction

    function automatic barm_pkg::req_t query_of(int q);
        barm_pkg::req_t r;
        r = noise_req(barm_pkg::MODE_QUERY);
        r.query_tile = 10'(q);
        return r;
    endfunction

    // Waits for the queue and the responses to drain, then for any sort or clear to finish.
    task automatic settle();
        while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [6:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            barm_pkg::CFG_BLOCK_SIZE:   reg_edge = value;
            barm_pkg::CFG_TILES_ACROSS: reg_across = value[5:0];
            barm_pkg::CFG_TILES_DOWN:   reg_down = value[5:0];
            default: ;
        endcase
        if (idx != CFG_UNUSED)
            is_sorted = 1'b0;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_grid(logic [6:0] edge_len, logic [6:0] across, logic [6:0] down);
        settle();
        write_reg(barm_pkg::CFG_BLOCK_SIZE, edge_len);
        write_reg(barm_pkg::CFG_TILES_ACROSS, across);
        write_reg(barm_pkg::CFG_TILES_DOWN, down);
    endtask

    // One random phase: clear, well-formed pixel runs, sort and queries, with some noise.
    task automatic random_phase(int count);
        int w;
        int h;
        int pick;
        w = eff_across() * eff_edge();
        h = eff_down() * eff_edge();
        queue_req(noise_req(barm_pkg::MODE_CLEAR));
        for (int i = 0; i < count; i++)
        begin
            if (i % 64 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 60)
                queue_req(pixel_at(1'($urandom_range(0, 1)),
                                   $urandom_range(0, w - 1), $urandom_range(0, h - 1)));
            else if (pick < 66)
                queue_req(noise_req(3'($urandom_range(barm_pkg::MODE_ORIG,
                                                      barm_pkg::MODE_REF))));
            else if (pick < 72)
                queue_req(noise_req(barm_pkg::MODE_SORT));
            else if (pick < 92)
                queue_req(query_of($urandom_range(0, tile_total())));
            else if (pick < 96)
                queue_req(noise_req(3'($urandom_range(MODE_SPARE, MODE_SPARE3))));
            else if (pick < 98)
                queue_req(noise_req(barm_pkg::MODE_QUERY));
            else
                queue_req(noise_req(barm_pkg::MODE_CLEAR));
        end
        queue_req(noise_req(barm_pkg::MODE_SORT));
        for (int i = 0; i < 8; i++)
            queue_req(query_of($urandom_range(0, tile_total() - 1)));
    endtask

    initial
    begin
        barm_pkg::req_t r;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        rsp_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        reqs_taken = 0;
        rsps_checked = 0;
        idle_cycles = 0;
        gap_left = 0;
        stall_left = 0;
        no_idle = 1'b0;
        hold_off = 1'b0;
        req_taken = 1'b0;
        rsp_taken = 1'b0;
        reg_edge = 7'd8;
        reg_across = 6'd32;
        reg_down = 6'd32;
        clear_sums();
        for (int i = 0; i < barm_pkg::MAX_TILES; i++)
            map_of_tile[i] = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset geometry: query before any sort, corners of the image, unused modes.
        queue_req(query_of(0));
        queue_req(pixel_at(0, 2047, 2047));
        queue_req(pixel_at(1, 255, 255));
        queue_req(pixel_at(0, 256, 0));
        queue_req(pixel_at(1, 0, 256));
        queue_req(noise_req(MODE_SPARE));
        queue_req(noise_req(MODE_SPARE2));
        queue_req(noise_req(MODE_SPARE3));
        queue_req(query_of(1023));
        queue_req(noise_req(barm_pkg::MODE_CLEAR));
        queue_req(query_of(5));

        // Out-of-range register values clamp to a single tile of one pixel.
        set_grid(7'd0, 7'd0, 7'd0);
        write_reg(CFG_UNUSED, 7'h7F);
        queue_req(pixel_at(0, 0, 0));
        queue_req(pixel_at(1, 1, 0));
        queue_req(noise_req(barm_pkg::MODE_SORT));
        queue_req(query_of(0));
        queue_req(query_of(1));
        queue_req(query_of(1023));

        // Equal keys: the empty reference tiles tie and rank by raster index.
        set_grid(7'd1, 7'd2, 7'd1);
        r = pixel_at(0, 0, 0);
        r.red = 8'd200;
        queue_req(r);
        r = pixel_at(0, 1, 0);
        r.red = 8'd100;
        queue_req(r);
        queue_req(noise_req(barm_pkg::MODE_SORT));
        queue_req(query_of(0));
        queue_req(query_of(1));

        // Average saturation: a 2x2 tile filled twice over with full-scale pixels.
        set_grid(7'd2, 7'd1, 7'd2);
        for (int i = 0; i < 8; i++)
        begin
            r = pixel_at(0, i % 2, (i / 2) % 2);
            r.red = 8'hFF;
            queue_req(r);
        end
        queue_req(noise_req(barm_pkg::MODE_SORT));
        queue_req(query_of(0));
        queue_req(query_of(1));

        // Random phases over several geometries, largest edge and widest row included.
        set_grid(7'h7F, 7'h3F, 7'd1);
        random_phase(80);
        set_grid(7'd3, 7'd1, 7'd32);
        random_phase(80);
        set_grid(7'd5, 7'd4, 7'd3);
        random_phase(40);
        while (pending_reqs.size() > 20)
            @(posedge clk);
        hold_off = 1'b1;
        while (expected_rsps.size() > 0)
            @(posedge clk);
        hold_off = 1'b0;
        random_phase(40);
        set_grid(7'd1, 7'd6, 7'd5);
        random_phase(80);
        set_grid(7'd64, 7'd2, 7'd2);
        random_phase(80);
        set_grid(7'd7, 7'd8, 7'd4);
        random_phase(40);
        settle();

        $display("covered %0d request transactions and %0d checked responses",
                 reqs_taken, rsps_checked);
        $display("geometries from one pixel tiles up to 64-pixel edges, with ties and saturation");
        if (errors == 0)
            $display("block_average_rank_matcher_test: PASS");
        else
            $display("block_average_rank_matcher_test: FAIL");
        $finish;
    end

endmodule

[sim.f]
rtl/barm_pkg.sv
rtl/barm_div.sv
rtl/block_average_rank_matcher.sv
rtl/barm_checker.sv
tb/block_average_rank_matcher_test.sv
